>>> rtl/ogdi_pkg.sv
// Shared types, constants and field layout for the occupancy grid inflation block.
// Used by the scanner, the top level and the checker; no dependencies of its own.
package ogdi_pkg;

	// Grid store geometry
	localparam int MAX_WIDTH  = 128;
	localparam int MAX_ROWS   = 128;
	localparam int MAX_REACH  = 15;
	localparam int X_W        = $clog2(MAX_WIDTH);
	localparam int Y_W        = $clog2(MAX_ROWS);
	localparam int ADDR_W     = X_W + Y_W;
	localparam int CELLS      = 1 << ADDR_W;

	// Register widths
	localparam int GW_W      = 8;
	localparam int GH_W      = 8;
	localparam int REACH_W   = 4;
	localparam int CLR_W     = 17;
	localparam int CFG_W     = 17;
	localparam int REG_IDX_W = 2;

	// Reach offsets and distance test
	localparam int OFF_W  = $clog2(MAX_REACH + 1) + 1;
	localparam int GAP_W  = $clog2(MAX_REACH + 1);
	localparam int Q_FRAC = 8;
	localparam int DIST_W = 2 * GAP_W + 1 + Q_FRAC;
	localparam int CMP_W  = (DIST_W > CLR_W) ? DIST_W : CLR_W;

	// Stream layout
	localparam int CMD_W     = 2;
	localparam int S_TDATA_W = ((CMD_W + X_W + Y_W + 7) / 8) * 8;
	localparam int M_TDATA_W = 8;

	// Command codes (code 3 behaves as a read)
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_MARK  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

	// Register indexes
	localparam logic [REG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_REACH       = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_CLEARANCE   = 2'd3;

	// Control from the sequencer to the neighborhood scanner
	typedef struct packed {
		logic start;
		logic adv;
	} scan_ctl_t;

	// Status from the scanner back to the sequencer
	typedef struct packed {
		logic              hit;
		logic              last;
		logic [ADDR_W-1:0] addr;
	} scan_stat_t;

endpackage

>>> rtl/ogdi_ram.sv
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module ogdi_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write and one read of the same address per cycle; a write reads the old data
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

>>> rtl/ogdi_scan.sv
// Neighborhood scanner: walks the (2R+1)^2 offsets of a mark, one per cycle,
// and flags the cells that pass the clearance test and lie inside the grid.
// Depends on ogdi_pkg.
module ogdi_scan (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ogdi_pkg::scan_ctl_t           ctl,
	input  logic [ogdi_pkg::X_W-1:0]      cx,
	input  logic [ogdi_pkg::Y_W-1:0]      cy,
	input  logic [ogdi_pkg::X_W:0]        w_eff,
	input  logic [ogdi_pkg::Y_W:0]        h_eff,
	input  logic [ogdi_pkg::REACH_W-1:0]  reach,
	input  logic [ogdi_pkg::CLR_W-1:0]    clearance,
	output ogdi_pkg::scan_stat_t          stat
);

	localparam int TX_W = ogdi_pkg::X_W + 2;
	localparam int TY_W = ogdi_pkg::Y_W + 2;
	localparam int SUM_W = 2 * ogdi_pkg::GAP_W + 1;

	logic signed [ogdi_pkg::OFF_W-1:0]  dx_q, dy_q;
	logic [ogdi_pkg::REACH_W-1:0]       r_eff;
	logic signed [ogdi_pkg::OFF_W-1:0]  r_pos, r_neg;
	logic [ogdi_pkg::OFF_W-1:0]         ax, ay;
	logic [ogdi_pkg::GAP_W-1:0]         gx, gy;
	logic [2*ogdi_pkg::GAP_W:0]         gap_sum;
	logic [ogdi_pkg::DIST_W-1:0]        dist_q8;
	logic                               in_disk;
	logic signed [TX_W-1:0]             tx;
	logic signed [TY_W-1:0]             ty;
	logic                               in_grid;

	// Clip reach and form the signed offset bounds
	always_comb begin
		r_eff = (reach > ogdi_pkg::REACH_W'(ogdi_pkg::MAX_REACH))
			? ogdi_pkg::REACH_W'(ogdi_pkg::MAX_REACH) : reach;
		r_pos = $signed(ogdi_pkg::OFF_W'(r_eff));
		r_neg = -r_pos;
	end

	// Offset counters, row-major
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dx_q <= '0;
			dy_q <= '0;
		end else if (ctl.start) begin
			dx_q <= r_neg;
			dy_q <= r_neg;
		end else if (ctl.adv) begin
			if (dx_q == r_pos) begin
				dx_q <= r_neg;
				dy_q <= dy_q + ogdi_pkg::OFF_W'(1);
			end else begin
				dx_q <= dx_q + ogdi_pkg::OFF_W'(1);
			end
		end
	end

	// Gap test: (gx^2 + gy^2) * 256 <= clearance
	always_comb begin
		ax      = dx_q[ogdi_pkg::OFF_W-1] ? ogdi_pkg::OFF_W'(-dx_q) : ogdi_pkg::OFF_W'(dx_q);
		ay      = dy_q[ogdi_pkg::OFF_W-1] ? ogdi_pkg::OFF_W'(-dy_q) : ogdi_pkg::OFF_W'(dy_q);
		gx      = (ax == '0) ? '0 : ogdi_pkg::GAP_W'(ax - ogdi_pkg::OFF_W'(1));
		gy      = (ay == '0) ? '0 : ogdi_pkg::GAP_W'(ay - ogdi_pkg::OFF_W'(1));
		gap_sum = (SUM_W'(gx) * SUM_W'(gx))
			+ (SUM_W'(gy) * SUM_W'(gy));
		dist_q8 = {gap_sum, {ogdi_pkg::Q_FRAC{1'b0}}};
		in_disk = ogdi_pkg::CMP_W'(dist_q8) <= ogdi_pkg::CMP_W'(clearance);
	end

	// Target cell and grid clipping
	always_comb begin
		tx      = $signed(TX_W'(cx)) + TX_W'(dx_q);
		ty      = $signed(TY_W'(cy)) + TY_W'(dy_q);
		in_grid = !tx[TX_W-1] && !ty[TY_W-1]
			&& (tx[TX_W-2:0] < w_eff) && (ty[TY_W-2:0] < h_eff);
	end

	assign stat.hit  = in_disk && in_grid;
	assign stat.last = (dx_q == r_pos) && (dy_q == r_pos);
	assign stat.addr = {ty[ogdi_pkg::Y_W-1:0], tx[ogdi_pkg::X_W-1:0]};

endmodule

>>> rtl/occupancy_grid_disk_inflation_top.sv
// Occupancy grid with disk-shaped obstacle inflation: top level, command sequencer.
// Depends on ogdi_pkg, ogdi_ram and ogdi_scan.
//
// Holds a raw and an inflated one-bit map of up to 128 x 128 cells, each in its
// own single-port RAM. One command is in flight at a time and each gives one
// result item. A read passes through the read and capture states; a mark walks
// the (2R+1)^2 neighbor offsets, R being reach_cells, since the inflated map's one
// write port sets one neighbor cell per cycle; a clear writes one RAM entry per
// cycle. After reset the block runs the same clearing pass with s_tready low;
// configuration writes are taken throughout. Results wait in an output register,
// so a stalled m_tready holds the block only once a second result is ready. Read
// and mark commands whose cell lies outside the grid return out_of_grid.
module occupancy_grid_disk_inflation_top (
	input  logic                               clk,
	input  logic                               arst_n,
	// cmd[1:0], cell_x[8:2], cell_y[15:9]
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [ogdi_pkg::S_TDATA_W-1:0]     s_tdata,
	// raw_bit[0], inflated_bit[1], out_of_grid[2], zero pad above
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [ogdi_pkg::M_TDATA_W-1:0]     m_tdata,
	input  logic                               cfg_we,
	input  logic [ogdi_pkg::REG_IDX_W-1:0]     cfg_index,
	input  logic [ogdi_pkg::CFG_W-1:0]         cfg_wdata
);

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_MARK,
		ST_RD,
		ST_CAP,
		ST_DONE
	} state_t;

	state_t                            state_q;
	logic [ogdi_pkg::X_W-1:0]          x_q;
	logic [ogdi_pkg::Y_W-1:0]          y_q;
	logic [ogdi_pkg::ADDR_W-1:0]       clr_addr_q;
	logic                              res_raw_q, res_infl_q, res_oob_q;
	logic                              out_valid_q;
	logic [2:0]                        out_bits_q;

	logic [ogdi_pkg::GW_W-1:0]         grid_width_q;
	logic [ogdi_pkg::GH_W-1:0]         grid_height_q;
	logic [ogdi_pkg::REACH_W-1:0]      reach_q;
	logic [ogdi_pkg::CLR_W-1:0]        clearance_q;

	logic [ogdi_pkg::CMD_W-1:0]        in_cmd;
	logic [ogdi_pkg::X_W-1:0]          in_x;
	logic [ogdi_pkg::Y_W-1:0]          in_y;
	logic [ogdi_pkg::X_W:0]            w_eff;
	logic [ogdi_pkg::Y_W:0]            h_eff;
	logic                              in_oob;
	logic                              accept;
	logic                              out_free;

	logic                              raw_we, raw_wdata, raw_rdata;
	logic                              infl_we, infl_wdata, infl_rdata;
	logic [ogdi_pkg::ADDR_W-1:0]       raw_addr, infl_addr, center_addr;

	ogdi_pkg::scan_ctl_t               scan_ctl;
	ogdi_pkg::scan_stat_t              scan_stat;

	// Input unpacking and grid bounds
	always_comb begin
		in_cmd = s_tdata[ogdi_pkg::CMD_W-1:0];
		in_x   = s_tdata[ogdi_pkg::CMD_W +: ogdi_pkg::X_W];
		in_y   = s_tdata[ogdi_pkg::CMD_W + ogdi_pkg::X_W +: ogdi_pkg::Y_W];
		w_eff  = (grid_width_q > ogdi_pkg::GW_W'(ogdi_pkg::MAX_WIDTH))
			? (ogdi_pkg::X_W+1)'(ogdi_pkg::MAX_WIDTH) : (ogdi_pkg::X_W+1)'(grid_width_q);
		h_eff  = (grid_height_q > ogdi_pkg::GH_W'(ogdi_pkg::MAX_ROWS))
			? (ogdi_pkg::Y_W+1)'(ogdi_pkg::MAX_ROWS) : (ogdi_pkg::Y_W+1)'(grid_height_q);
		in_oob = ((ogdi_pkg::X_W+1)'(in_x) >= w_eff) || ((ogdi_pkg::Y_W+1)'(in_y) >= h_eff);
	end

	assign s_tready    = (state_q == ST_IDLE);
	assign accept      = s_tvalid && s_tready;
	assign out_free    = !out_valid_q || m_tready;
	assign center_addr = {y_q, x_q};

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= ogdi_pkg::GW_W'(ogdi_pkg::MAX_WIDTH);
			grid_height_q <= ogdi_pkg::GH_W'(ogdi_pkg::MAX_ROWS);
			reach_q       <= '0;
			clearance_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				ogdi_pkg::REG_GRID_WIDTH:  grid_width_q  <= cfg_wdata[ogdi_pkg::GW_W-1:0];
				ogdi_pkg::REG_GRID_HEIGHT: grid_height_q <= cfg_wdata[ogdi_pkg::GH_W-1:0];
				ogdi_pkg::REG_REACH:       reach_q       <= cfg_wdata[ogdi_pkg::REACH_W-1:0];
				ogdi_pkg::REG_CLEARANCE:   clearance_q   <= cfg_wdata[ogdi_pkg::CLR_W-1:0];
				default: ;
			endcase
		end
	end

	// Scanner control
	always_comb begin
		scan_ctl.start = accept && (in_cmd == ogdi_pkg::CMD_MARK) && !in_oob;
		scan_ctl.adv   = (state_q == ST_MARK);
	end

	// RAM port selection
	always_comb begin
		raw_we     = 1'b0;
		raw_wdata  = 1'b0;
		raw_addr   = center_addr;
		infl_we    = 1'b0;
		infl_wdata = 1'b0;
		infl_addr  = center_addr;
		case (state_q)
			ST_INIT, ST_CLEAR: begin
				raw_we    = 1'b1;
				raw_addr  = clr_addr_q;
				infl_we   = 1'b1;
				infl_addr = clr_addr_q;
			end
			ST_MARK: begin
				raw_we     = 1'b1;
				raw_wdata  = 1'b1;
				infl_we    = scan_stat.hit;
				infl_wdata = 1'b1;
				infl_addr  = scan_stat.addr;
			end
			default: ;
		endcase
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
			out_bits_q  <= '0;
			x_q         <= '0;
			y_q         <= '0;
			res_raw_q   <= 1'b0;
			res_infl_q  <= 1'b0;
			res_oob_q   <= 1'b0;
		end else begin
			// load from the done state, drop once taken
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_INIT: begin
					clr_addr_q <= clr_addr_q + ogdi_pkg::ADDR_W'(1);
					if (&clr_addr_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						x_q <= in_x;
						y_q <= in_y;
						if (in_cmd == ogdi_pkg::CMD_CLEAR) begin
							clr_addr_q <= '0;
							state_q    <= ST_CLEAR;
						end else if (in_oob) begin
							res_raw_q  <= 1'b0;
							res_infl_q <= 1'b0;
							res_oob_q  <= 1'b1;
							state_q    <= ST_DONE;
						end else if (in_cmd == ogdi_pkg::CMD_MARK) begin
							state_q <= ST_MARK;
						end else begin
							state_q <= ST_RD;
						end
					end
				end
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + ogdi_pkg::ADDR_W'(1);
					if (&clr_addr_q) begin
						res_raw_q  <= 1'b0;
						res_infl_q <= 1'b0;
						res_oob_q  <= 1'b0;
						state_q    <= ST_DONE;
					end
				end
				ST_MARK: begin
					if (scan_stat.last) begin
						res_raw_q  <= 1'b1;
						res_infl_q <= 1'b1;
						res_oob_q  <= 1'b0;
						state_q    <= ST_DONE;
					end
				end
				ST_RD: begin
					state_q <= ST_CAP;
				end
				ST_CAP: begin
					res_raw_q  <= raw_rdata;
					res_infl_q <= infl_rdata;
					res_oob_q  <= 1'b0;
					state_q    <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_bits_q <= {res_oob_q, res_infl_q, res_raw_q};
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(ogdi_pkg::M_TDATA_W-3){1'b0}}, out_bits_q};

	ogdi_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (scan_ctl),
		.cx        (x_q),
		.cy        (y_q),
		.w_eff     (w_eff),
		.h_eff     (h_eff),
		.reach     (reach_q),
		.clearance (clearance_q),
		.stat      (scan_stat)
	);

	ogdi_ram #(
		.WIDTH (1),
		.DEPTH (ogdi_pkg::CELLS)
	) u_raw_map (
		.clk   (clk),
		.we    (raw_we),
		.addr  (raw_addr),
		.wdata (raw_wdata),
		.rdata (raw_rdata)
	);

	ogdi_ram #(
		.WIDTH (1),
		.DEPTH (ogdi_pkg::CELLS)
	) u_infl_map (
		.clk   (clk),
		.we    (infl_we),
		.addr  (infl_addr),
		.wdata (infl_wdata),
		.rdata (infl_rdata)
	);

endmodule

>>> rtl/ogdi_checker.sv
// Port-level checker for the occupancy grid inflation block, bound to its top level.
// Depends on ogdi_pkg.
module ogdi_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_tvalid,
	input logic                               s_tready,
	input logic                               m_tvalid,
	input logic                               m_tready,
	input logic [ogdi_pkg::M_TDATA_W-1:0]     m_tdata
);

	// A stalled result item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result item changed while stalled");

	// One command at a time: ready drops after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while a command is in flight");

	// An ignored command reports no occupancy
	a_oob_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2] |-> !m_tdata[0] && !m_tdata[1])
		else $error("out_of_grid result with occupancy bits set");

	// Every raw cell is also inflated
	a_raw_implies_infl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[1])
		else $error("raw bit set without inflated bit");

endmodule

bind occupancy_grid_disk_inflation_top ogdi_checker u_ogdi_checker (.*);
